@@ hw/rtl/tsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared constants, types and codes of the touch sample to pixel unit.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // screen geometry and sample width, fixed by the field widths of the ports
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int SAMPLE_BITS   = 10;

  // output field widths
  localparam int COL_BITS = 9;
  localparam int ROW_BITS = 8;

  // quotient bits: enough for the larger screen size itself
  localparam int MAX_SIZE  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int QUOT_BITS = $clog2(MAX_SIZE + 1);

  // product of screen size and sample offset
  localparam int PROD_BITS = SAMPLE_BITS + QUOT_BITS;

  // depth of each lane pipeline, from input transfer to lane result
  localparam int LANE_LATENCY = QUOT_BITS + 2;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_LOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_HIGH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_LOW  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_HIGH = 2'd3;

  // how an axis reading maps against its limits
  typedef enum logic [1:0] {
    SCALE_BELOW,
    SCALE_ABOVE,
    SCALE_ZERO_SPAN,
    SCALE_DIVIDE
  } scale_mode_t;

  // result of one axis lane
  typedef struct packed {
    logic [QUOT_BITS-1:0] value;
    logic                 fault;
  } lane_res_t;

endpackage

@@ hw/rtl/tsp_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_lane
// One axis: limit compare, scaling by the screen size and a pipelined
// restoring divider that settles one quotient bit per stage.
// ----------------------------------------------------------------------------
module tsp_lane #(
  parameter int SIZE = 320
) (
  input  logic                             clk,
  input  logic                             adv,
  input  logic [tsp_pkg::SAMPLE_BITS-1:0]  raw,
  input  logic [tsp_pkg::SAMPLE_BITS-1:0]  low_limit,
  input  logic [tsp_pkg::SAMPLE_BITS-1:0]  high_limit,
  output tsp_pkg::lane_res_t               res
);

  localparam int SB = tsp_pkg::SAMPLE_BITS;
  localparam int QW = tsp_pkg::QUOT_BITS;
  localparam int PW = tsp_pkg::PROD_BITS;

  // first stage: offset, span and mode
  logic [SB-1:0]        diff;
  logic [SB-1:0]        span_a;
  tsp_pkg::scale_mode_t mode_a;
  tsp_pkg::scale_mode_t mode_sel;

  always_comb begin
    if (raw < low_limit) begin
      mode_sel = tsp_pkg::SCALE_BELOW;
    end else if (raw > high_limit) begin
      mode_sel = tsp_pkg::SCALE_ABOVE;
    end else if (high_limit == low_limit) begin
      mode_sel = tsp_pkg::SCALE_ZERO_SPAN;
    end else begin
      mode_sel = tsp_pkg::SCALE_DIVIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff   <= raw - low_limit;
      span_a <= high_limit - low_limit;
      mode_a <= mode_sel;
    end
  end

  // divider stage registers, index 0 holds the scaled dividend
  logic [PW-1:0]        rem  [0:QW];
  logic [QW-1:0]        quo  [0:QW];
  logic [SB-1:0]        span [0:QW];
  tsp_pkg::scale_mode_t mode [0:QW];

  // second stage: multiply offset by the screen size
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]  <= PW'(diff) * PW'(SIZE);
      quo[0]  <= '0;
      span[0] <= span_a;
      mode[0] <= mode_a;
    end
  end

  // one trial subtract per stage, most significant quotient bit first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int J = QW - 1 - k;
    logic [PW-1:0] trial;
    logic          take;

    assign trial = PW'(span[k]) << J;
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1]  <= take ? rem[k] - trial : rem[k];
        quo[k+1]  <= quo[k] | (take ? (QW'(1) << J) : '0);
        span[k+1] <= span[k];
        mode[k+1] <= mode[k];
      end
    end
  end

  // pick the lane result by mode
  always_comb begin
    res.fault = 1'b0;
    case (mode[QW])
      tsp_pkg::SCALE_BELOW: begin
        res.value = '0;
      end
      tsp_pkg::SCALE_ABOVE: begin
        res.value = QW'(SIZE - 1);
      end
      tsp_pkg::SCALE_ZERO_SPAN: begin
        res.value = '0;
        res.fault = 1'b1;
      end
      default: begin
        res.value = quo[QW];
      end
    endcase
  end

endmodule

@@ hw/rtl/tsp_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_merge
// Combines the two axis lanes: inverts Y, joins the fault flags and holds
// the result in the output register that drives the master side.
// ----------------------------------------------------------------------------
module tsp_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tsp_pkg::lane_res_t x_res,
  input  tsp_pkg::lane_res_t y_res,
  output logic               adv,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,   // column[8:0], row[16:9], zero pad
  output logic [0:0]         m_tuser    // divide_fault
);

  localparam int QW = tsp_pkg::QUOT_BITS;
  localparam logic [QW:0] HEIGHT = (QW + 1)'(tsp_pkg::SCREEN_HEIGHT);

  logic [QW:0]                   row_full;
  logic [tsp_pkg::COL_BITS-1:0]  column;
  logic [tsp_pkg::ROW_BITS-1:0]  row;

  // pipeline moves whenever the output register is free or being drained
  assign adv = !m_tvalid || m_tready;

  // y inversion, row may reach the full height
  assign row_full = HEIGHT - {1'b0, y_res.value};
  assign row      = row_full[tsp_pkg::ROW_BITS-1:0];
  assign column   = x_res.value[tsp_pkg::COL_BITS-1:0];

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {7'd0, row, column};
      m_tuser <= x_res.fault | y_res.fault;
    end
  end

endmodule

@@ hw/rtl/touch_sample_to_pixel_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_to_pixel_unit
// Maps a raw touch-panel ADC pair to screen pixel coordinates with
// two-point calibration limits.
// ----------------------------------------------------------------------------
// The unit takes one sample transfer per cycle and gives one result per
// sample once that sample has passed the limit compare and scaling stages,
// 9 divider stages and the output register. X and Y run in two lanes
// side by side, each with its own pipelined divider of one quotient bit per
// stage; those divider stages set the latency. A stall on the master side
// holds the whole pipeline and drops s_tready. Calibration limits reset to
// zero and should be written while no sample is in flight.
// ----------------------------------------------------------------------------
module touch_sample_to_pixel_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [tsp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tsp_pkg::SAMPLE_BITS-1:0]     cfg_data,
  // sample input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,   // raw_x[9:0], raw_y[19:10], zero pad
  // pixel output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,   // column[8:0], row[16:9], zero pad
  output logic [0:0]                          m_tuser    // divide_fault
);

  localparam int SB  = tsp_pkg::SAMPLE_BITS;
  localparam int LAT = tsp_pkg::LANE_LATENCY;

  logic [SB-1:0] x_low_limit;
  logic [SB-1:0] x_high_limit;
  logic [SB-1:0] y_low_limit;
  logic [SB-1:0] y_high_limit;

  logic               adv;
  logic [LAT-1:0]     vld;
  tsp_pkg::lane_res_t x_res;
  tsp_pkg::lane_res_t y_res;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low_limit  <= '0;
      x_high_limit <= '0;
      y_low_limit  <= '0;
      y_high_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsp_pkg::CFG_X_LOW:  x_low_limit  <= cfg_data;
        tsp_pkg::CFG_X_HIGH: x_high_limit <= cfg_data;
        tsp_pkg::CFG_Y_LOW:  y_low_limit  <= cfg_data;
        tsp_pkg::CFG_Y_HIGH: y_high_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = adv;

  // valid bits that travel alongside the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // x lane
  tsp_lane #(
    .SIZE (tsp_pkg::SCREEN_WIDTH)
  ) u_lane_x (
    .clk        (clk),
    .adv        (adv),
    .raw        (s_tdata[SB-1:0]),
    .low_limit  (x_low_limit),
    .high_limit (x_high_limit),
    .res        (x_res)
  );

  // y lane
  tsp_lane #(
    .SIZE (tsp_pkg::SCREEN_HEIGHT)
  ) u_lane_y (
    .clk        (clk),
    .adv        (adv),
    .raw        (s_tdata[2*SB-1:SB]),
    .low_limit  (y_low_limit),
    .high_limit (y_high_limit),
    .res        (y_res)
  );

  // merge and output register
  tsp_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[LAT-1]),
    .x_res    (x_res),
    .y_res    (y_res),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ tb/sv/tb_touch_sample_to_pixel_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_sample_to_pixel_unit
// Self-checking bench for the touch sample to pixel unit. Raw X/Y sample
// pairs are sent over the input stream and the screen coordinates that come
// back are compared field by field with a calibration-mapping predictor.
// The run steps through sets of calibration limits: reset values, typical,
// full range, low above high, zero span, narrow, mixed and zero span at the
// rails, each under one of four source-gap and sink back-pressure patterns.
// ----------------------------------------------------------------------------
module tb_touch_sample_to_pixel_unit;

  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 130;

  typedef struct packed {
    logic [tsp_pkg::SAMPLE_BITS-1:0] raw_x;
    logic [tsp_pkg::SAMPLE_BITS-1:0] raw_y;
  } touch_sample_t;

  typedef struct packed {
    logic [tsp_pkg::COL_BITS-1:0] column;
    logic [tsp_pkg::ROW_BITS-1:0] row;
    logic                         divide_fault;
  } pixel_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [tsp_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [tsp_pkg::SAMPLE_BITS-1:0]  cfg_data = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [23:0]                      s_tdata = '0;   // raw_x[9:0], raw_y[19:10], zero pad
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [23:0]                      m_tdata;        // column[8:0], row[16:9], zero pad
  logic [0:0]                       m_tuser;        // divide_fault

  // calibration limits as the bench believes them to be
  logic [tsp_pkg::SAMPLE_BITS-1:0] x_low_cal = '0;
  logic [tsp_pkg::SAMPLE_BITS-1:0] x_high_cal = '0;
  logic [tsp_pkg::SAMPLE_BITS-1:0] y_low_cal = '0;
  logic [tsp_pkg::SAMPLE_BITS-1:0] y_high_cal = '0;

  touch_sample_t sample_q[$];
  pixel_t        pixel_due_q[$];
  touch_sample_t sample_on_bus;
  pixel_t        due_pixel;
  int            send_gap_pct = 0;
  int            sink_stall_pct = 0;
  int            mismatches = 0;
  int            quiet_cycles = 0;

  touch_sample_to_pixel_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // one axis against its two-point limits; low above high never divides
  function automatic int unsigned map_axis(input int unsigned raw, input int unsigned lo,
                                           input int unsigned hi, input int unsigned size,
                                           output bit zero_span);
    zero_span = 1'b0;
    if (raw < lo) return 0;
    if (raw > hi) return size - 1;
    if (hi == lo) begin
      zero_span = 1'b1;
      return 0;
    end
    return (size * (raw - lo)) / (hi - lo);
  endfunction

  function automatic pixel_t predict_pixel(input touch_sample_t smp);
    pixel_t      px;
    bit          x_zero;
    bit          y_zero;
    int unsigned col;
    int unsigned y_scaled;
    col = map_axis(smp.raw_x, x_low_cal, x_high_cal, tsp_pkg::SCREEN_WIDTH, x_zero);
    y_scaled = map_axis(smp.raw_y, y_low_cal, y_high_cal, tsp_pkg::SCREEN_HEIGHT, y_zero);
    px.column = col[tsp_pkg::COL_BITS-1:0];
    px.row = 8'(tsp_pkg::SCREEN_HEIGHT - y_scaled);
    px.divide_fault = x_zero | y_zero;
    return px;
  endfunction

  // reading biased toward the limits, just outside them, the region between them and the rails
  function automatic logic [tsp_pkg::SAMPLE_BITS-1:0] pick_raw(input int unsigned lo,
                                                               input int unsigned hi);
    int unsigned v;
    case ($urandom_range(0, 9))
      4: v = lo;
      5: v = hi;
      6: v = lo - $urandom_range(1, 3);
      7: v = hi + $urandom_range(1, 3);
      8: v = $urandom_range(hi, lo);
      9: v = $urandom_range(0, 1) ? 1023 : 0;
      default: v = $urandom_range(0, 1023);
    endcase
    return v[tsp_pkg::SAMPLE_BITS-1:0];
  endfunction

  task automatic queue_sample(input int unsigned rx, input int unsigned ry);
    touch_sample_t smp;
    smp.raw_x = rx[tsp_pkg::SAMPLE_BITS-1:0];
    smp.raw_y = ry[tsp_pkg::SAMPLE_BITS-1:0];
    sample_q.push_back(smp);
  endtask

  task automatic queue_random_samples(input int count);
    repeat (count) begin
      queue_sample(pick_raw(x_low_cal, x_high_cal), pick_raw(y_low_cal, y_high_cal));
    end
  endtask

  task automatic write_limit(input logic [tsp_pkg::CFG_IDX_BITS-1:0] idx,
                             input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[tsp_pkg::SAMPLE_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tsp_pkg::CFG_X_LOW:  x_low_cal = value[tsp_pkg::SAMPLE_BITS-1:0];
      tsp_pkg::CFG_X_HIGH: x_high_cal = value[tsp_pkg::SAMPLE_BITS-1:0];
      tsp_pkg::CFG_Y_LOW:  y_low_cal = value[tsp_pkg::SAMPLE_BITS-1:0];
      default:             y_high_cal = value[tsp_pkg::SAMPLE_BITS-1:0];
    endcase
  endtask

  task automatic program_calibration(input int unsigned xl, input int unsigned xh,
                                     input int unsigned yl, input int unsigned yh);
    write_limit(tsp_pkg::CFG_X_LOW, xl);
    write_limit(tsp_pkg::CFG_X_HIGH, xh);
    write_limit(tsp_pkg::CFG_Y_LOW, yl);
    write_limit(tsp_pkg::CFG_Y_HIGH, yh);
  endtask

  // gap and stall pattern for a phase
  task automatic set_traffic(input int mode);
    case (mode % 4)
      0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
      1: begin send_gap_pct = 80; sink_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  sink_stall_pct = 80; end
      default: begin send_gap_pct = 35; sink_stall_pct = 35; end
    endcase
  endtask

  // wait until every queued sample went in and every pixel came out
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_q.size() != 0 || s_tvalid || pixel_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sample source: holds data until transfer, random gaps between samples
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        pixel_due_q.push_back(predict_pixel(sample_on_bus));
      end
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          sample_on_bus = sample_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, sample_on_bus.raw_y, sample_on_bus.raw_x};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // pixel sink: random back-pressure, check each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pixel_due_q.size() == 0) begin
          $error("pixel transfer with no sample pending: tdata=%h tuser=%b", m_tdata, m_tuser);
          mismatches++;
        end else begin
          due_pixel = pixel_due_q.pop_front();
          if (m_tdata[8:0] !== due_pixel.column) begin
            $error("column: expected %0d, got %0d", due_pixel.column, m_tdata[8:0]);
            mismatches++;
          end
          if (m_tdata[16:9] !== due_pixel.row) begin
            $error("row: expected %0d, got %0d", due_pixel.row, m_tdata[16:9]);
            mismatches++;
          end
          if (m_tuser[0] !== due_pixel.divide_fault) begin
            $error("divide_fault: expected %0b, got %0b", due_pixel.divide_fault, m_tuser[0]);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset limits are all zero: zero span at the bottom rail, full scale above it
    set_traffic(0);
    queue_sample(0, 0);
    queue_sample(1023, 1023);
    queue_sample(0, 5);
    queue_sample(5, 0);
    queue_random_samples(40);
    wait_drained();

    for (int phase = 1; phase <= 7; phase++) begin
      case (phase)
        1: program_calibration(80, 950, 120, 900);    // typical panel
        2: program_calibration(0, 1023, 0, 1023);     // full range
        3: program_calibration(900, 100, 700, 300);   // low above high
        4: program_calibration(512, 512, 1023, 1023); // zero span
        5: program_calibration(0, 1, 1022, 1023);     // narrowest span
        6: program_calibration(0, 1023, 1023, 0);     // mixed extremes
        default: program_calibration(1023, 1023, 0, 0);
      endcase
      set_traffic(phase);
      if (phase == 1) begin
        // limits, one step outside them, rails, a mid-range point and alternating bit patterns
        queue_sample(0, 1023);
        queue_sample(1023, 0);
        queue_sample(79, 119);
        queue_sample(80, 120);
        queue_sample(81, 121);
        queue_sample(949, 899);
        queue_sample(950, 900);
        queue_sample(951, 901);
        queue_sample(515, 510);
        queue_sample(10'h2AA, 10'h155);
        queue_sample(10'h155, 10'h2AA);
      end
      queue_random_samples(RANDOM_ITEMS);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (pixel_due_q.size() != 0) begin
      $error("%0d pixel results never arrived", pixel_due_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
